// ----- design/escaped_length_frame_deframer_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the escaped length frame deframer
// Concurrent checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define ESCAPED_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define ELD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");
// next-cycle implication
`define ELD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");
`else
`define ELD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ELD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/eld_pkg.sv -----
// ----------------------------------------------------------------------------
// eld_pkg
// Types, codes and the unescape table for the frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package eld_pkg;

   // parse phase codes
   localparam logic [2:0] PH_HDR1   = 3'd0;
   localparam logic [2:0] PH_HDR2   = 3'd1;
   localparam logic [2:0] PH_LENH   = 3'd2;
   localparam logic [2:0] PH_LENL   = 3'd3;
   localparam logic [2:0] PH_BODY   = 3'd4;
   localparam logic [2:0] PH_FOLLOW = 3'd5;

   // configuration register indexes
   localparam logic CSR_ESCAPE_CODE   = 1'b0;
   localparam logic CSR_TRAILER_COUNT = 1'b1;

   // register reset values
   localparam logic [7:0] ESCAPE_CODE_RESET   = 8'h10;
   localparam logic [1:0] TRAILER_COUNT_RESET = 2'd2;

   localparam int POSITION_WIDTH  = 18;
   localparam int REMAINING_WIDTH = 17;

   typedef struct packed {
      logic [7:0]                data_byte;
      logic [2:0]                phase;
      logic [POSITION_WIDTH-1:0] frame_index;
      logic [15:0]               payload_length;
      logic                      end_of_frame;
   } result_type;

   // escaped follower to byte value; codes outside 0x30..0x37 map to themselves
   function automatic logic [7:0] unescape_byte(input logic [7:0] code);
      logic [7:0] mapped;
      begin
         case (code)
            8'h30:   mapped = 8'h16;
            8'h31:   mapped = 8'h2c;
            8'h32:   mapped = 8'h58;
            8'h33:   mapped = 8'hb0;
            8'h34:   mapped = 8'h61;
            8'h35:   mapped = 8'hc2;
            8'h36:   mapped = 8'h85;
            8'h37:   mapped = 8'h0b;
            default: mapped = code;
         endcase
         return mapped;
      end
   endfunction

endpackage

`default_nettype wire

// ----- design/eld_channels.sv -----
// ----------------------------------------------------------------------------
// Deframer channel interfaces
// Valid/ready channels for received bytes and for annotated results.
// ----------------------------------------------------------------------------
`default_nettype none

interface eld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface eld_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [7:0]                         data_byte;
   logic [2:0]                         phase;
   logic [eld_pkg::POSITION_WIDTH-1:0] frame_index;
   logic [15:0]                        payload_length;
   logic                               end_of_frame;

   modport source (output valid, output data_byte, output phase, output frame_index,
                   output payload_length, output end_of_frame, input ready);
   modport sink (input valid, input data_byte, input phase, input frame_index,
                 input payload_length, input end_of_frame, output ready);
endinterface

`default_nettype wire

// ----- design/escaped_length_frame_deframer_core.sv -----
// An accepted byte waits in the input register until the result register is free,
// then moves there and is offered as its result transaction. Throughput: one byte
// per cycle while the receiver takes results; the phase machine updates once per byte.
// Input and result registers let a new byte enter while a result waits.
// Reset (synchronous, active high) empties both registers, returns the parser
// to the first header byte and restores escape code 0x10 and trailer count 2.
// ----------------------------------------------------------------------------
// escaped_length_frame_deframer_core
// Annotates each received byte with frame phase, index, length and end mark.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_length_frame_deframer_core (
   input  wire logic       clock,
   input  wire logic       reset,
   eld_req_if.sink         req_chan,
   eld_rsp_if.source       rsp_chan,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_write_data
);

   logic                byte_valid;
   logic [7:0]          byte_data;
   logic                slot_free;
   logic                advance;
   eld_pkg::result_type result;

   // byte moves from input register to result register
   assign advance = byte_valid && slot_free;

   eld_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   eld_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .advance          (advance),
      .byte_data        (byte_data),
      .result           (result)
   );

   eld_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- design/eld_input_stage.sv -----
// ----------------------------------------------------------------------------
// eld_input_stage
// Input register for received bytes; refills in the cycle it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module eld_input_stage (
   input  wire logic  clock,
   input  wire logic  reset,
   eld_req_if.sink    req_chan,
   input  wire logic  advance,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   // take a new transaction when empty or draining this cycle
   assign req_chan.ready = !valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_chan.rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

`default_nettype wire

// ----- design/eld_parser.sv -----
// ----------------------------------------------------------------------------
// eld_parser
// Frame phase machine and configuration registers; annotates one byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "escaped_length_frame_deframer_core_assert.svh"

module eld_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_write_data,
   input  wire logic        advance,
   input  wire logic [7:0]  byte_data,
   output eld_pkg::result_type result
);

   localparam int PW = eld_pkg::POSITION_WIDTH;
   localparam int RW = eld_pkg::REMAINING_WIDTH;

   logic [7:0]    escape_code_ff;
   logic [1:0]    trailer_count_ff;

   logic [2:0]    phase_ff, phase_in;
   logic          pending_ff, pending_in;
   logic [7:0]    length_high_ff, length_high_in;
   logic [15:0]   length_ff, length_in;
   logic [RW-1:0] remaining_ff, remaining_in;
   logic [PW-1:0] position_ff, position_in;

   logic          is_escape;
   logic          done;
   logic [7:0]    unescaped;
   logic [7:0]    low_byte;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_code_ff   <= eld_pkg::ESCAPE_CODE_RESET;
         trailer_count_ff <= eld_pkg::TRAILER_COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            eld_pkg::CSR_ESCAPE_CODE:   escape_code_ff   <= csr_write_data;
            eld_pkg::CSR_TRAILER_COUNT: trailer_count_ff <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   assign is_escape = (byte_data == escape_code_ff);
   assign unescaped = eld_pkg::unescape_byte(byte_data);
   assign low_byte  = pending_ff ? unescaped : byte_data;

   // next state for the byte in the input register
   always_comb begin
      phase_in       = phase_ff;
      pending_in     = pending_ff;
      length_high_in = length_high_ff;
      length_in      = length_ff;
      remaining_in   = remaining_ff;
      done           = 1'b0;
      case (phase_ff)
         eld_pkg::PH_HDR1: begin
            length_in      = 16'd0;
            length_high_in = 8'd0;
            phase_in       = eld_pkg::PH_HDR2;
         end
         eld_pkg::PH_HDR2: begin
            phase_in = eld_pkg::PH_LENH;
         end
         eld_pkg::PH_LENH: begin
            if (pending_ff) begin
               length_high_in = unescaped;
               pending_in     = 1'b0;
               phase_in       = eld_pkg::PH_LENL;
            end else if (is_escape) begin
               pending_in = 1'b1;
            end else begin
               length_high_in = byte_data;
               phase_in       = eld_pkg::PH_LENL;
            end
         end
         eld_pkg::PH_LENL: begin
            if (!pending_ff && is_escape) begin
               pending_in = 1'b1;
            end else begin
               pending_in   = 1'b0;
               length_in    = {length_high_ff, low_byte};
               remaining_in = RW'({length_high_ff, low_byte}) + RW'(trailer_count_ff);
               if (remaining_in == '0) begin
                  done = 1'b1;
               end else begin
                  phase_in = eld_pkg::PH_BODY;
               end
            end
         end
         default: begin
            // body: an escape code and its follower count as one unit
            if (pending_ff) begin
               pending_in   = 1'b0;
               remaining_in = remaining_ff - RW'(1);
            end else if (is_escape) begin
               pending_in = 1'b1;
            end else begin
               remaining_in = remaining_ff - RW'(1);
            end
            done = !pending_in && (remaining_in == '0);
         end
      endcase
      if (done) begin
         phase_in     = eld_pkg::PH_HDR1;
         pending_in   = 1'b0;
         remaining_in = '0;
         position_in  = '0;
      end else begin
         position_in  = position_ff + PW'(1);
      end
   end

   // parser state moves only when the byte goes to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= eld_pkg::PH_HDR1;
         pending_ff     <= 1'b0;
         length_high_ff <= 8'd0;
         length_ff      <= 16'd0;
         remaining_ff   <= '0;
         position_ff    <= '0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         pending_ff     <= pending_in;
         length_high_ff <= length_high_in;
         length_ff      <= length_in;
         remaining_ff   <= remaining_in;
         position_ff    <= position_in;
      end
   end

   // annotated result
   always_comb begin
      result.data_byte      = byte_data;
      result.phase          = pending_ff ? eld_pkg::PH_FOLLOW : phase_ff;
      result.frame_index    = position_ff;
      result.payload_length = length_in;
      result.end_of_frame   = done;
   end

   `ELD_ASSERT_NEXT(a_eof_restarts, clock, reset, advance && done, (phase_ff == eld_pkg::PH_HDR1) && (position_ff == '0) && !pending_ff)
   `ELD_ASSERT_NEXT(a_position_steps, clock, reset, advance && !done, position_ff == $past(position_ff) + PW'(1))
   `ELD_ASSERT_IMPLIES(a_body_nonempty, clock, reset, phase_ff == eld_pkg::PH_BODY, remaining_ff != '0)
   `ELD_ASSERT_IMPLIES(a_pending_phase, clock, reset, pending_ff, (phase_ff == eld_pkg::PH_LENH) || (phase_ff == eld_pkg::PH_LENL) || (phase_ff == eld_pkg::PH_BODY))

endmodule

`default_nettype wire

// ----- design/eld_output_stage.sv -----
// ----------------------------------------------------------------------------
// eld_output_stage
// Result register; accepts a new result while the current one drains.
// ----------------------------------------------------------------------------
`default_nettype none

module eld_output_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire eld_pkg::result_type result,
   output logic                     slot_free,
   eld_rsp_if.source                rsp_chan
);

   logic                valid_ff, valid_in;
   eld_pkg::result_type result_ff;

   assign slot_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.data_byte      = result_ff.data_byte;
   assign rsp_chan.phase          = result_ff.phase;
   assign rsp_chan.frame_index    = result_ff.frame_index;
   assign rsp_chan.payload_length = result_ff.payload_length;
   assign rsp_chan.end_of_frame   = result_ff.end_of_frame;

endmodule

`default_nettype wire

// ----- dv/escaped_length_frame_deframer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_length_frame_deframer_core_tb
// Drives received bytes into the deframer and checks every annotated result
// (byte, phase, frame index, decoded length, end mark) against typed values or a
// cycle-free model of the frame parser. A short directed table comes first, then random
// frames under several escape/trailer settings, sender gaps, receiver stalls
// and one long receiver hold-off.
// ----------------------------------------------------------------------------

module escaped_length_frame_deframer_core_tb;

   localparam int CLOCK_PERIOD    = 10;
   localparam int PHASE_BYTES     = 200;
   localparam int SETTLE_CYCLES   = 6;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 4000;

   // 0x30..0x37 escaped followers, entry k at bits 8k+7..8k
   localparam logic [63:0] FOLLOWER_MAP = {8'h0b, 8'h85, 8'hc2, 8'h61,
                                           8'hb0, 8'h58, 8'h2c, 8'h16};

   localparam eld_pkg::result_type NO_RESULT = '0;

   typedef enum logic [1:0] {ROW_CSR, ROW_CHECKED, ROW_PREDICTED} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic                csr_sel;
      logic [7:0]          value;
      eld_pkg::result_type want;
   } stim_row_type;

   // directed table: typed results where they are obvious
   localparam stim_row_type DIRECTED_ROWS [29] = '{
      // escape 0x10, trailer 2: escaped length low, escape pair in body
      '{ROW_CHECKED, 1'b0, 8'hFF, '{8'hFF, eld_pkg::PH_HDR1,   18'd0, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h00, '{8'h00, eld_pkg::PH_HDR2,   18'd1, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h00, '{8'h00, eld_pkg::PH_LENH,   18'd2, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h10, '{8'h10, eld_pkg::PH_LENL,   18'd3, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h01, '{8'h01, eld_pkg::PH_FOLLOW, 18'd4, 16'd1, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h10, '{8'h10, eld_pkg::PH_BODY,   18'd5, 16'd1, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h10, '{8'h10, eld_pkg::PH_FOLLOW, 18'd6, 16'd1, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h55, '{8'h55, eld_pkg::PH_BODY,   18'd7, 16'd1, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'hFF, '{8'hFF, eld_pkg::PH_BODY,   18'd8, 16'd1, 1'b1}},
      '{ROW_CSR, eld_pkg::CSR_TRAILER_COUNT, 8'h00, NO_RESULT},
      '{ROW_CSR, eld_pkg::CSR_ESCAPE_CODE,   8'hFF, NO_RESULT},
      // escape 0xFF, trailer 0: empty body ends on the escaped low follower
      '{ROW_CHECKED, 1'b0, 8'hFF, '{8'hFF, eld_pkg::PH_HDR1,   18'd0, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'hFF, '{8'hFF, eld_pkg::PH_HDR2,   18'd1, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'hFF, '{8'hFF, eld_pkg::PH_LENH,   18'd2, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h00, '{8'h00, eld_pkg::PH_FOLLOW, 18'd3, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'hFF, '{8'hFF, eld_pkg::PH_LENL,   18'd4, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h00, '{8'h00, eld_pkg::PH_FOLLOW, 18'd5, 16'd0, 1'b1}},
      // empty body ends on a plain low byte
      '{ROW_CHECKED, 1'b0, 8'h00, '{8'h00, eld_pkg::PH_HDR1,   18'd0, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h00, '{8'h00, eld_pkg::PH_HDR2,   18'd1, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h00, '{8'h00, eld_pkg::PH_LENH,   18'd2, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h00, '{8'h00, eld_pkg::PH_LENL,   18'd3, 16'd0, 1'b1}},
      '{ROW_CSR, eld_pkg::CSR_ESCAPE_CODE,   8'h00, NO_RESULT},
      '{ROW_CSR, eld_pkg::CSR_TRAILER_COUNT, 8'h03, NO_RESULT},
      // escape 0x00, trailer 3: escape code as a follower, mapped low follower
      '{ROW_CHECKED, 1'b0, 8'hAA, '{8'hAA, eld_pkg::PH_HDR1,   18'd0, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h55, '{8'h55, eld_pkg::PH_HDR2,   18'd1, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h00, '{8'h00, eld_pkg::PH_LENH,   18'd2, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h00, '{8'h00, eld_pkg::PH_FOLLOW, 18'd3, 16'd0, 1'b0}},
      '{ROW_CHECKED, 1'b0, 8'h00, '{8'h00, eld_pkg::PH_LENL,   18'd4, 16'd0, 1'b0}},
      '{ROW_PREDICTED, 1'b0, 8'h37, NO_RESULT}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic       csr_index;
   logic [7:0] csr_write_data;

   eld_req_if req_if ();
   eld_rsp_if rsp_if ();

   escaped_length_frame_deframer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // parser model state and its copy of the registers
   logic [7:0]                         cur_escape   = eld_pkg::ESCAPE_CODE_RESET;
   logic [1:0]                         cur_trailer  = eld_pkg::TRAILER_COUNT_RESET;
   logic [2:0]                         parse_state  = eld_pkg::PH_HDR1;
   logic                               follower_due = 1'b0;
   logic [7:0]                         len_hi       = '0;
   logic [15:0]                        len_word     = '0;
   logic [16:0]                        units_left   = '0;
   logic [eld_pkg::POSITION_WIDTH-1:0] byte_pos     = '0;

   eld_pkg::result_type annotated_bytes_due [$];

   int  sender_idle_pct    = 0;
   int  receiver_stall_pct = 0;
   bit  hold_request       = 1'b0;
   int  hold_cycles_left   = 0;
   int  quiet_cycles       = 0;
   int  mismatches         = 0;
   int  bytes_sent         = 0;
   int  frames_closed      = 0;
   int  settings_run       = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic logic [7:0] unescape_follower(input logic [7:0] code);
      if (code[7:3] == 5'b00110)
         return FOLLOWER_MAP[code[2:0] * 8 +: 8];
      return code;
   endfunction

   // byte that unescapes to v, or -1 when none does
   function automatic int follower_for(input logic [7:0] v);
      for (int k = 0; k < 8; k++)
         if (FOLLOWER_MAP[k * 8 +: 8] == v)
            return 'h30 + k;
      if (v[7:3] == 5'b00110)
         return -1;
      return int'(v);
   endfunction

   // one byte through the parser: annotation out, state advanced
   function automatic eld_pkg::result_type deframe_byte(input logic [7:0] b);
      eld_pkg::result_type r;
      logic                follower;
      logic                have_low;
      logic [7:0]          low;
      logic                done;
      follower = follower_due;
      done     = 1'b0;
      have_low = 1'b0;
      low      = b;
      r.data_byte   = b;
      r.phase       = follower ? eld_pkg::PH_FOLLOW : parse_state;
      r.frame_index = byte_pos;
      case (parse_state)
         eld_pkg::PH_HDR1: begin
            len_word    = '0;
            len_hi      = '0;
            parse_state = eld_pkg::PH_HDR2;
         end
         eld_pkg::PH_HDR2: parse_state = eld_pkg::PH_LENH;
         eld_pkg::PH_LENH: begin
            if (follower) begin
               len_hi       = unescape_follower(b);
               follower_due = 1'b0;
               parse_state  = eld_pkg::PH_LENL;
            end else if (b == cur_escape) begin
               follower_due = 1'b1;
            end else begin
               len_hi      = b;
               parse_state = eld_pkg::PH_LENL;
            end
         end
         eld_pkg::PH_LENL: begin
            if (follower) begin
               low          = unescape_follower(b);
               follower_due = 1'b0;
               have_low     = 1'b1;
            end else if (b == cur_escape) begin
               follower_due = 1'b1;
            end else begin
               have_low = 1'b1;
            end
            // trailer count is latched here, once per frame
            if (have_low) begin
               len_word   = {len_hi, low};
               units_left = {1'b0, len_word} + 17'(cur_trailer);
               if (units_left == '0)
                  done = 1'b1;
               else
                  parse_state = eld_pkg::PH_BODY;
            end
         end
         default: begin
            if (follower) begin
               follower_due = 1'b0;
               units_left   = units_left - 17'd1;
            end else if (b == cur_escape) begin
               follower_due = 1'b1;
            end else begin
               units_left = units_left - 17'd1;
            end
            if (!follower_due && units_left == '0)
               done = 1'b1;
         end
      endcase
      r.payload_length = len_word;
      r.end_of_frame   = done;
      if (done) begin
         parse_state  = eld_pkg::PH_HDR1;
         follower_due = 1'b0;
         units_left   = '0;
         byte_pos     = '0;
      end else begin
         byte_pos = byte_pos + 18'd1;
      end
      return r;
   endfunction

   // entered and left at a falling edge; valid stays up for the next byte
   task automatic send_rx_byte(input logic [7:0] b, input bit typed,
                               input eld_pkg::result_type want);
      eld_pkg::result_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      predicted = deframe_byte(b);
      annotated_bytes_due.push_back(typed ? want : predicted);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_rx_byte(b, 1'b0, NO_RESULT);
   endtask

   // stop offering, let every result drain, end on a falling edge
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (annotated_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic sel, input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= sel;
      csr_write_data   <= data;
      if (sel == eld_pkg::CSR_ESCAPE_CODE)
         cur_escape = data;
      else
         cur_trailer = data[1:0];
      @(negedge clock);
   endtask

   // length byte, escaped at random or when it equals the escape code and has a follower
   task automatic send_length_byte(input logic [7:0] v);
      int f;
      f = follower_for(v);
      if (f >= 0 && (v == cur_escape || $urandom_range(0, 3) == 0)) begin
         send_byte(cur_escape);
         send_byte(f[7:0]);
      end else begin
         send_byte(v);
      end
   endtask

   // mostly well-formed frames, some noise and some cut short
   task automatic send_frame();
      int          pick;
      int          units;
      logic [15:0] len;
      logic [7:0]  b;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         repeat ($urandom_range(1, 6)) begin
            b = 8'($urandom_range(0, 255));
            send_byte(b);
         end
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            len = 16'($urandom_range(0, 12));
         else if (pick < 95)
            len = 16'($urandom_range(13, 60));
         else if (pick < 99)
            len = 16'($urandom_range(61, 255));
         else
            len = 16'($urandom_range(256, 700));
         repeat (2) begin
            b = 8'($urandom_range(0, 255));
            send_byte(b);
         end
         send_length_byte(len[15:8]);
         send_length_byte(len[7:0]);
         units = int'(len) + int'(cur_trailer);
         if ($urandom_range(0, 99) < 5)
            units = int'($urandom_range(0, units));
         repeat (units) begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0) begin
               send_byte(cur_escape);
               send_byte(b);
            end else begin
               if (b == cur_escape)
                  b = b ^ 8'h01;
               send_byte(b);
            end
         end
      end
   endtask

   task automatic run_phase(input logic [7:0] esc, input logic [1:0] trl, input int send_idle,
                            input int rsp_stall, input bit squeeze);
      int         target;
      logic [7:0] junk;
      wait_idle();
      junk = 8'($urandom_range(0, 63));
      write_register(eld_pkg::CSR_ESCAPE_CODE, esc);
      write_register(eld_pkg::CSR_TRAILER_COUNT, {junk[5:0], trl});
      csr_write_enable <= 1'b0;
      @(posedge clock);
      sender_idle_pct    = send_idle;
      receiver_stall_pct = rsp_stall;
      hold_request       = squeeze;
      @(negedge clock);
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target)
         send_frame();
      settings_run++;
   endtask

   function automatic void check_result();
      eld_pkg::result_type want;
      if (annotated_bytes_due.size() == 0) begin
         $error("result transaction with nothing expected: data_byte %0h", rsp_if.data_byte);
         mismatches++;
      end else begin
         want = annotated_bytes_due.pop_front();
         if (rsp_if.data_byte !== want.data_byte) begin
            $error("data_byte: expected %0h, got %0h", want.data_byte, rsp_if.data_byte);
            mismatches++;
         end
         if (rsp_if.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, rsp_if.phase);
            mismatches++;
         end
         if (rsp_if.frame_index !== want.frame_index) begin
            $error("frame_index: expected %0d, got %0d", want.frame_index, rsp_if.frame_index);
            mismatches++;
         end
         if (rsp_if.payload_length !== want.payload_length) begin
            $error("payload_length: expected %0h, got %0h",
                   want.payload_length, rsp_if.payload_length);
            mismatches++;
         end
         if (rsp_if.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame: expected %0b, got %0b", want.end_of_frame, rsp_if.end_of_frame);
            mismatches++;
         end
      end
      if (rsp_if.end_of_frame === 1'b1)
         frames_closed++;
   endfunction

   // receiver pacing: random stalls, plus the long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_cycles_left = HOLD_OFF_CYCLES;
         hold_request     = 1'b0;
      end
      if (hold_cycles_left > 0) begin
         hold_cycles_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // result check and watchdog on quiet stretches
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("FAILURE");
            $finish;
         end else if (rsp_if.valid && rsp_if.ready) begin
            check_result();
         end
      end
   end

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = 1'b0;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.rx_byte   = '0;
      rsp_if.ready     = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED_ROWS[i]) begin
         case (DIRECTED_ROWS[i].kind)
            ROW_CSR: begin
               wait_idle();
               write_register(DIRECTED_ROWS[i].csr_sel, DIRECTED_ROWS[i].value);
               csr_write_enable <= 1'b0;
            end
            ROW_CHECKED:
               send_rx_byte(DIRECTED_ROWS[i].value, 1'b1, DIRECTED_ROWS[i].want);
            default:
               send_byte(DIRECTED_ROWS[i].value);
         endcase
      end

      // random frames: escape code, trailer count, sender idle %, receiver stall %, hold-off
      run_phase(8'h10, 2'd2, 0, 0, 1'b0);
      run_phase(8'h00, 2'd0, 73, 0, 1'b0);
      run_phase(8'hFF, 2'd3, 0, 73, 1'b0);
      run_phase(8'h30, 2'd1, 10, 10, 1'b0);
      run_phase(8'h16, 2'd2, 0, 0, 1'b1);
      run_phase(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), 73, 0, 1'b0);
      run_phase(8'($urandom_range(0, 255)), 2'd0, 0, 73, 1'b0);
      run_phase(8'h7D, 2'd3, 10, 10, 1'b0);
      run_phase(8'h37, 2'd1, 0, 0, 1'b0);
      wait_idle();

      $display("Covered %0d bytes and %0d closed frames over %0d random register settings,",
               bytes_sent, frames_closed, settings_run);
      $display("with sender gaps, receiver stalls and a %0d-cycle receiver hold-off",
               HOLD_OFF_CYCLES);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/eld_pkg.sv
design/eld_channels.sv
design/eld_input_stage.sv
design/eld_parser.sv
design/eld_output_stage.sv
design/escaped_length_frame_deframer_core.sv
dv/escaped_length_frame_deframer_core_tb.sv
